// ===== sv/dense_graph_shortest_path_core_assert.svh =====
// Assertion macros shared by the shortest path core.
`ifndef DENSE_GRAPH_SHORTEST_PATH_CORE_ASSERT_SVH
`define DENSE_GRAPH_SHORTEST_PATH_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DGSP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define DGSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== sv/dgsp_pkg.sv =====
// Shared constants, codes and types of the shortest path core.
package dgsp_pkg;

  localparam int MAX_NODES   = 32;
  localparam int NODE_BITS   = $clog2(MAX_NODES);
  localparam int CNT_BITS    = NODE_BITS + 1;
  localparam int CELL_BITS   = 2 * NODE_BITS;
  localparam int WEIGHT_BITS = 24;
  localparam int MULT_BITS   = 16;
  localparam int FRAC_BITS   = 8;
  localparam int EV_BITS     = 2;
  localparam int ROW_BITS    = MAX_NODES * EV_BITS;
  localparam int PROD_BITS   = WEIGHT_BITS + MULT_BITS;
  localparam int MODE_BITS   = 2;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_NODE_BITS = 6;

  localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX = '1;
  localparam logic [MULT_BITS-1:0]   MULT_ONE   = MULT_BITS'(1 << FRAC_BITS);

  // input modes
  localparam logic [MODE_BITS-1:0] MODE_WEIGHT = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_EVENT  = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_QUERY  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_EVENT1     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_EVENT2     = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_EVENT3     = 2'd3;

  // edge event codes
  localparam logic [EV_BITS-1:0] EV_NONE  = 2'd0;
  localparam logic [EV_BITS-1:0] EV_TYPE1 = 2'd1;
  localparam logic [EV_BITS-1:0] EV_TYPE2 = 2'd2;
  localparam logic [EV_BITS-1:0] EV_TYPE3 = 2'd3;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EV_ROW1,
    ST_EV_ROW2,
    ST_PICK,
    ST_RELAX,
    ST_TAIL,
    ST_FB_READ,
    ST_FB_MUL,
    ST_FB_SAT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [WEIGHT_BITS-1:0] pick_dist;
    logic [WEIGHT_BITS-1:0] weight;
    logic [WEIGHT_BITS-1:0] best;
    logic [EV_BITS-1:0]     ev;
    logic                   is_pick;
    logic                   reached;
    logic                   settled;
    logic                   cand_found;
    logic [WEIGHT_BITS-1:0] cand_dist;
  } relax_in_t;

  typedef struct packed {
    logic                   update;
    logic [WEIGHT_BITS-1:0] sum;
    logic                   take;
    logic [WEIGHT_BITS-1:0] new_best;
  } relax_out_t;

endpackage

// ===== sv/dgsp_relax.sv =====
// Edge relaxation and running minimum for one neighbor of the picked node.
module dgsp_relax import dgsp_pkg::*; (
  input  relax_in_t  ri,
  output relax_out_t ro
);

  logic [WEIGHT_BITS:0]   raw;
  logic [WEIGHT_BITS-1:0] sum;
  logic                   upd;
  logic                   now_reached;

  always_comb begin
    raw = {1'b0, ri.pick_dist} + {1'b0, ri.weight};
    sum = raw[WEIGHT_BITS] ? WEIGHT_MAX : raw[WEIGHT_BITS-1:0];
    // zero weight means no edge; any event blocks the edge
    upd = !ri.is_pick && (ri.weight != '0) && (ri.ev == EV_NONE) &&
          (!ri.reached || (sum < ri.best));
    now_reached = ri.reached || upd;
    ro.update   = upd;
    ro.sum      = sum;
    ro.new_best = upd ? sum : ri.best;
    // strict compare in ascending node order keeps the lowest index on ties
    ro.take     = now_reached && !ri.settled &&
                  (!ri.cand_found || (ro.new_best < ri.cand_dist));
  end

endmodule

// ===== sv/dense_graph_shortest_path_core.sv =====
// Top level: dense graph weight and event store with a shortest path query engine.
//
//  channel  direction  handshake            word
//  input    in         in_valid / in_stall   mode, from_node, to_node, weight, event_req
//  output   out        out_valid / out_stall distance, path_found, index_error
//  config   in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// Weight write: one memory write. Event write: read-modify-write of the from_node event row
// and, unless the nodes match, the to_node row. Query: bad index or same node goes straight
// to the result; otherwise each settled node takes a pick, the one-entry-a-cycle scan of the
// weight memory row and a tail, and an unreached target adds the fallback read and multiply.
// Reset starts a clearing pass over all 32 event memory rows; in_stall is high.
// A finished result waits in the output register; out_stall holds only the final transfer.
module dense_graph_shortest_path_core import dgsp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [MODE_BITS-1:0]    mode,
  input  logic [NODE_BITS-1:0]    from_node,
  input  logic [NODE_BITS-1:0]    to_node,
  input  logic [WEIGHT_BITS-1:0]  weight,
  input  logic [EV_BITS-1:0]      event_req,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [WEIGHT_BITS-1:0]  distance,
  output logic                    path_found,
  output logic                    index_error,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [MULT_BITS-1:0]    cfg_data
);

  `include "dense_graph_shortest_path_core_assert.svh"

  state_t state, state_next;

  logic [NODE_BITS-1:0]     clr_cnt;
  logic [CFG_NODE_BITS-1:0] node_count;
  logic [MULT_BITS-1:0]     mult1, mult2, mult3;
  logic [CNT_BITS-1:0]      n_eff;
  logic                     idx_ok;

  logic [NODE_BITS-1:0]     q_from, q_to;
  logic [EV_BITS-1:0]       q_ev;
  logic [MAX_NODES-1:0]     reached, settled;
  logic [NODE_BITS-1:0]     pick;
  logic [WEIGHT_BITS-1:0]   pick_dist;
  logic [CNT_BITS-1:0]      iss_cnt;
  logic                     s2_valid;
  logic [NODE_BITS-1:0]     s2_v;
  logic                     cand_found;
  logic [NODE_BITS-1:0]     cand_node;
  logic [WEIGHT_BITS-1:0]   cand_dist;
  logic [PROD_BITS-1:0]     prod;
  logic                     base_zero;
  logic [MULT_BITS-1:0]     mult_sel;
  logic [EV_BITS-1:0]       fb_ev;
  logic [WEIGHT_BITS-1:0]   res_dist;
  logic                     res_found, res_err;
  logic                     out_load;

  // weight memory
  logic [WEIGHT_BITS-1:0] wmem [MAX_NODES*MAX_NODES];
  logic                   w_wr_en, w_rd_en;
  logic [CELL_BITS-1:0]   w_rd_addr;
  logic [WEIGHT_BITS-1:0] wq;

  // event memory, one row of all columns per entry
  logic [ROW_BITS-1:0]  emem [MAX_NODES];
  logic                 e_wr_en, e_rd_en;
  logic [NODE_BITS-1:0] e_wr_addr, e_rd_addr;
  logic [ROW_BITS-1:0]  e_wr_data;
  logic [ROW_BITS-1:0]  erow;

  // working distance memory
  logic [WEIGHT_BITS-1:0] bmem [MAX_NODES];
  logic                   b_wr_en, b_rd_en;
  logic [NODE_BITS-1:0]   b_wr_addr, b_rd_addr;
  logic [WEIGHT_BITS-1:0] b_wr_data;
  logic [WEIGHT_BITS-1:0] bq;

  relax_in_t  ri;
  relax_out_t ro;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign n_eff     = (node_count > CFG_NODE_BITS'(MAX_NODES)) ? CNT_BITS'(MAX_NODES)
                                                             : CNT_BITS'(node_count);
  assign idx_ok    = (CNT_BITS'(from_node) < n_eff) && (CNT_BITS'(to_node) < n_eff);

  always_comb begin
    ri.pick_dist  = pick_dist;
    ri.weight     = wq;
    ri.best       = bq;
    ri.ev         = erow[{s2_v, 1'b0} +: EV_BITS];
    ri.is_pick    = (s2_v == pick);
    ri.reached    = reached[s2_v];
    ri.settled    = settled[s2_v];
    ri.cand_found = cand_found;
    ri.cand_dist  = cand_dist;
  end

  dgsp_relax u_relax (
    .ri (ri),
    .ro (ro)
  );

  always_comb begin
    fb_ev = erow[{q_to, 1'b0} +: EV_BITS];
    case (fb_ev)
      EV_TYPE1: mult_sel = mult1;
      EV_TYPE2: mult_sel = mult2;
      EV_TYPE3: mult_sel = mult3;
      default:  mult_sel = MULT_ONE;
    endcase
  end

  // next state and memory controls
  always_comb begin
    state_next = state;
    w_wr_en    = 1'b0;
    w_rd_en    = 1'b0;
    w_rd_addr  = {q_from, q_to};
    e_wr_en    = 1'b0;
    e_wr_addr  = q_from;
    e_wr_data  = erow;
    e_rd_en    = 1'b0;
    e_rd_addr  = q_from;
    b_wr_en    = 1'b0;
    b_wr_addr  = s2_v;
    b_wr_data  = ro.sum;
    b_rd_en    = 1'b0;
    b_rd_addr  = iss_cnt[NODE_BITS-1:0];
    out_load   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        e_wr_en   = 1'b1;
        e_wr_addr = clr_cnt;
        e_wr_data = '0;
        if (clr_cnt == NODE_BITS'(MAX_NODES - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (mode)
            MODE_WEIGHT: w_wr_en = 1'b1;
            MODE_EVENT: begin
              if (idx_ok) begin
                e_rd_en    = 1'b1;
                e_rd_addr  = from_node;
                state_next = ST_EV_ROW1;
              end
            end
            MODE_QUERY: begin
              if (!idx_ok || (from_node == to_node)) begin
                state_next = ST_DONE;
              end else begin
                b_wr_en    = 1'b1;
                b_wr_addr  = from_node;
                b_wr_data  = '0;
                state_next = ST_PICK;
              end
            end
            default: ;
          endcase
        end
      end
      ST_EV_ROW1: begin
        e_wr_en   = 1'b1;
        e_wr_addr = q_from;
        e_wr_data[{q_to, 1'b0} +: EV_BITS] = q_ev;
        if (q_from != q_to) begin
          e_rd_en    = 1'b1;
          e_rd_addr  = q_to;
          state_next = ST_EV_ROW2;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EV_ROW2: begin
        e_wr_en   = 1'b1;
        e_wr_addr = q_to;
        e_wr_data[{q_from, 1'b0} +: EV_BITS] = q_ev;
        state_next = ST_IDLE;
      end
      ST_PICK: begin
        if (pick == q_to) begin
          state_next = ST_DONE;
        end else begin
          e_rd_en    = 1'b1;
          e_rd_addr  = pick;
          state_next = ST_RELAX;
        end
      end
      ST_RELAX: begin
        w_rd_en   = 1'b1;
        w_rd_addr = {pick, iss_cnt[NODE_BITS-1:0]};
        b_rd_en   = 1'b1;
        b_wr_en   = s2_valid && ro.update;
        if (iss_cnt == n_eff - CNT_BITS'(1)) state_next = ST_TAIL;
      end
      ST_TAIL: begin
        b_wr_en = s2_valid && ro.update;
        state_next = (cand_found || ro.take) ? ST_PICK : ST_FB_READ;
      end
      ST_FB_READ: begin
        w_rd_en    = 1'b1;
        e_rd_en    = 1'b1;
        state_next = ST_FB_MUL;
      end
      ST_FB_MUL: state_next = ST_FB_SAT;
      ST_FB_SAT: state_next = ST_DONE;
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (w_wr_en) wmem[{from_node, to_node}] <= weight;
    if (w_rd_en) wq <= wmem[w_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (e_wr_en) emem[e_wr_addr] <= e_wr_data;
    if (e_rd_en) erow <= emem[e_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (b_wr_en) bmem[b_wr_addr] <= b_wr_data;
    if (b_rd_en) bq <= bmem[b_rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_cnt    <= '0;
      node_count <= '0;
      mult1      <= MULT_ONE;
      mult2      <= MULT_ONE;
      mult3      <= MULT_ONE;
      reached    <= '0;
      settled    <= '0;
      s2_valid   <= 1'b0;
      cand_found <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state    <= state_next;
      s2_valid <= (state == ST_RELAX);
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + NODE_BITS'(1);
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_NODE_COUNT: node_count <= cfg_data[CFG_NODE_BITS-1:0];
          CFG_EVENT1:     mult1 <= cfg_data;
          CFG_EVENT2:     mult2 <= cfg_data;
          CFG_EVENT3:     mult3 <= cfg_data;
          default: ;
        endcase
      end
      if ((state == ST_IDLE) && in_valid) begin
        reached <= MAX_NODES'(1) << from_node;
        settled <= '0;
      end
      if (state == ST_PICK) begin
        settled[pick] <= 1'b1;
        cand_found    <= 1'b0;
      end
      if (s2_valid) begin
        if (ro.update) reached[s2_v] <= 1'b1;
        if (ro.take) cand_found <= 1'b1;
      end
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  // query datapath
  always_ff @(posedge clk) begin
    s2_v <= iss_cnt[NODE_BITS-1:0];
    if (s2_valid && ro.take) begin
      cand_node <= s2_v;
      cand_dist <= ro.new_best;
    end
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          q_from    <= from_node;
          q_to      <= to_node;
          q_ev      <= event_req;
          pick      <= from_node;
          pick_dist <= '0;
          res_dist  <= '0;
          res_err   <= !idx_ok;
          res_found <= idx_ok;
        end
      end
      ST_PICK: begin
        iss_cnt <= '0;
        if (pick == q_to) begin
          res_dist  <= pick_dist;
          res_found <= 1'b1;
          res_err   <= 1'b0;
        end
      end
      ST_RELAX: iss_cnt <= iss_cnt + CNT_BITS'(1);
      ST_TAIL: begin
        // advance to the nearest unsettled node, the last neighbor included
        pick      <= ro.take ? s2_v : cand_node;
        pick_dist <= ro.take ? ro.new_best : cand_dist;
      end
      ST_FB_MUL: begin
        prod      <= PROD_BITS'(wq) * PROD_BITS'(mult_sel);
        base_zero <= (wq == '0);
      end
      ST_FB_SAT: begin
        res_found <= 1'b0;
        res_err   <= 1'b0;
        if (base_zero) res_dist <= '0;
        else if (prod[PROD_BITS-1:WEIGHT_BITS+FRAC_BITS] != '0) res_dist <= WEIGHT_MAX;
        else res_dist <= prod[WEIGHT_BITS+FRAC_BITS-1:FRAC_BITS];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      distance    <= res_dist;
      path_found  <= res_found;
      index_error <= res_err;
    end
  end

  `DGSP_ASSERT_NOW(a_settled_reached, 1'b1, ((settled & ~reached) == '0))
  `DGSP_ASSERT_NOW(a_pick_open, state == ST_PICK, reached[pick] && !settled[pick])
  `DGSP_ASSERT_NOW(a_stage2_scan, s2_valid, (state == ST_RELAX) || (state == ST_TAIL))
  `DGSP_ASSERT_NEXT(a_done_holds, (state == ST_DONE) && out_valid && out_stall,
                    state == ST_DONE)

endmodule

// ===== verif/dense_graph_shortest_path_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the dense graph shortest path core: predicted answers vs. the block.
module dense_graph_shortest_path_core_test;
  import dgsp_pkg::*;

  localparam int WATCHDOG_LIMIT = 10000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int PHASES         = 7;
  localparam logic [MODE_BITS-1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic [WEIGHT_BITS-1:0] distance;
    logic                   path_found;
    logic                   index_error;
  } answer_t;

  // Tracks the graph and the registers, and owes one answer per accepted query.
  class path_ledger;
    logic [WEIGHT_BITS-1:0]   weights [MAX_NODES*MAX_NODES];
    logic [EV_BITS-1:0]       events  [MAX_NODES*MAX_NODES];
    logic [CFG_NODE_BITS-1:0] node_count;
    logic [MULT_BITS-1:0]     scale [4];
    answer_t                  owed [$];
    int                       mismatches;

    function new();
      foreach (weights[i]) weights[i] = '0;
      foreach (events[i]) events[i] = EV_NONE;
      node_count = '0;
      foreach (scale[i]) scale[i] = MULT_ONE;
      mismatches = 0;
    endfunction

    function void set_register(input logic [CFG_IDX_BITS-1:0] idx,
                               input logic [MULT_BITS-1:0] data);
      case (idx)
        CFG_NODE_COUNT: node_count = data[CFG_NODE_BITS-1:0];
        CFG_EVENT1:     scale[EV_TYPE1] = data;
        CFG_EVENT2:     scale[EV_TYPE2] = data;
        CFG_EVENT3:     scale[EV_TYPE3] = data;
        default: ;
      endcase
    endfunction

    function void note_word(input logic [MODE_BITS-1:0] m, input logic [NODE_BITS-1:0] f,
                            input logic [NODE_BITS-1:0] t, input logic [WEIGHT_BITS-1:0] w,
                            input logic [EV_BITS-1:0] e);
      int n, pick, slot;
      logic [WEIGHT_BITS-1:0] best [MAX_NODES];
      bit closed [MAX_NODES];
      bit seen [MAX_NODES];
      bit done;
      logic [WEIGHT_BITS:0] sum;
      logic [PROD_BITS-1:0] prod;
      answer_t a;
      n = (node_count > MAX_NODES) ? MAX_NODES : int'(node_count);
      case (m)
        MODE_WEIGHT: weights[{f, t}] = w;
        MODE_EVENT: begin
          if (f < n && t < n) begin
            events[{f, t}] = e;
            events[{t, f}] = e;
          end
        end
        MODE_QUERY: begin
          a = '0;
          if (f >= n || t >= n) begin
            a.index_error = 1'b1;
          end else if (f == t) begin
            a.path_found = 1'b1;
          end else begin
            foreach (best[i]) begin
              best[i] = '0;
              closed[i] = 1'b0;
              seen[i] = 1'b0;
            end
            seen[f] = 1'b1;
            done = 1'b0;
            while (!done) begin
              pick = -1;
              // lowest index wins a tie
              for (int u = 0; u < n; u++)
                if (seen[u] && !closed[u] && (pick < 0 || best[u] < best[pick])) pick = u;
              if (pick < 0 || pick == t) begin
                done = 1'b1;
              end else begin
                closed[pick] = 1'b1;
                for (int v = 0; v < n; v++) begin
                  slot = pick * MAX_NODES + v;
                  if (v != pick && weights[slot] != '0 && events[slot] == EV_NONE) begin
                    sum = {1'b0, best[pick]} + {1'b0, weights[slot]};
                    if (sum[WEIGHT_BITS]) sum[WEIGHT_BITS-1:0] = WEIGHT_MAX;
                    if (!seen[v] || sum[WEIGHT_BITS-1:0] < best[v]) begin
                      best[v] = sum[WEIGHT_BITS-1:0];
                      seen[v] = 1'b1;
                    end
                  end
                end
              end
            end
            if (seen[t]) begin
              a.distance = best[t];
              a.path_found = 1'b1;
            end else if (weights[{f, t}] != '0) begin
              // scale the direct edge by its event multiplier, 8.8 fixed
              prod = PROD_BITS'(weights[{f, t}]) * PROD_BITS'(scale[events[{f, t}]]);
              prod = prod >> FRAC_BITS;
              a.distance = (prod > PROD_BITS'(WEIGHT_MAX)) ? WEIGHT_MAX
                                                           : prod[WEIGHT_BITS-1:0];
            end
          end
          owed.insert(owed.size(), a);
        end
        default: ;
      endcase
    endfunction

    function void check_answer(input logic [WEIGHT_BITS-1:0] d, input logic pf,
                               input logic ie);
      answer_t want;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected word distance %h path_found %b index_error %b",
                   $time, d, pf, ie);
      end else begin
        want = owed.pop_front();
        if (d !== want.distance || pf !== want.path_found || ie !== want.index_error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch distance/path_found/index_error exp %h/%b/%b got %h/%b/%b",
                     $time, want.distance, want.path_found, want.index_error, d, pf, ie);
        end
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  logic [MODE_BITS-1:0]    mode;
  logic [NODE_BITS-1:0]    from_node;
  logic [NODE_BITS-1:0]    to_node;
  logic [WEIGHT_BITS-1:0]  weight;
  logic [EV_BITS-1:0]      event_req;
  logic                    out_valid;
  logic                    out_stall;
  logic [WEIGHT_BITS-1:0]  distance;
  logic                    path_found;
  logic                    index_error;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [MULT_BITS-1:0]    cfg_data;

  path_ledger ledger = new();
  bit         written [MAX_NODES*MAX_NODES];
  int         idle_pct = 37;
  int         quiet_cycles = 0;

  dense_graph_shortest_path_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .from_node(from_node), .to_node(to_node),
    .weight(weight), .event_req(event_req),
    .out_valid(out_valid), .out_stall(out_stall),
    .distance(distance), .path_found(path_found), .index_error(index_error),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // result side: take words, stall at random
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) ledger.check_answer(distance, path_found, index_error);
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
    begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [WEIGHT_BITS-1:0] rand_weight();
    int roll = $urandom_range(99);
    if (roll < 40) return '0;
    if (roll < 80) return WEIGHT_BITS'($urandom_range(1, 2048));
    if (roll < 90) return WEIGHT_MAX - WEIGHT_BITS'($urandom_range(0, 3));
    return WEIGHT_BITS'($urandom);
  endfunction

  function automatic logic [NODE_BITS-1:0] pick_node(input int n);
    if (n > 0 && $urandom_range(9) != 0) return NODE_BITS'($urandom_range(n - 1));
    return NODE_BITS'($urandom_range(MAX_NODES - 1));
  endfunction

  task automatic send_word(input logic [MODE_BITS-1:0] m, input logic [NODE_BITS-1:0] f,
                           input logic [NODE_BITS-1:0] t, input logic [WEIGHT_BITS-1:0] w,
                           input logic [EV_BITS-1:0] e);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    mode      <= m;
    from_node <= f;
    to_node   <= t;
    weight    <= w;
    event_req <= e;
    do @(posedge clk); while (in_stall);
    if (m == MODE_WEIGHT) written[{f, t}] = 1'b1;
    ledger.note_word(m, f, t, w, e);
  endtask

  task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                input logic [MULT_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    ledger.set_register(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait out all owed answers plus the tail of any write still in flight
  task automatic settle();
    in_valid <= 1'b0;
    while (ledger.owed.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // load every never-written cell a query over n nodes can touch
  task automatic fill_matrix(input int n, input bit blank);
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++)
        if (!written[r * MAX_NODES + c])
          send_word(MODE_WEIGHT, NODE_BITS'(r), NODE_BITS'(c),
                    blank ? '0 : rand_weight(), EV_BITS'($urandom_range(3)));
  endtask

  // loops_only keeps queries on a single node, so no weight row is scanned
  task automatic random_word(input int n, input bit loops_only);
    int roll;
    logic [NODE_BITS-1:0] f, t;
    logic [EV_BITS-1:0] e;
    roll = $urandom_range(99);
    f = pick_node(n);
    t = pick_node(n);
    e = ($urandom_range(99) < 55) ? EV_NONE : EV_BITS'($urandom_range(1, 3));
    if (roll < 30) begin
      send_word(MODE_WEIGHT, f, t, rand_weight(), EV_BITS'($urandom_range(3)));
    end else if (roll < 50) begin
      send_word(MODE_EVENT, f, t, WEIGHT_BITS'($urandom), e);
    end else if (roll < 96) begin
      if (loops_only || $urandom_range(9) == 0) t = f;
      send_word(MODE_QUERY, f, t, WEIGHT_BITS'($urandom), EV_BITS'($urandom_range(3)));
    end else begin
      send_word(MODE_SPARE, f, t, WEIGHT_BITS'($urandom), EV_BITS'($urandom_range(3)));
    end
  endtask

  initial begin
    logic [MULT_BITS-1:0] setting [PHASES][4];
    int bulk [PHASES];
    int nodes;
    setting = '{'{16'd2, 16'h0000, 16'hFFFF, 16'h0100},
                '{16'd5, 16'h0080, 16'h0200, 16'hFFFF},
                '{16'd8, 16'hFFFF, 16'h0000, 16'h0180},
                '{16'd12, 16'h0100, 16'h0040, 16'h0000},
                '{16'hFFE3, 16'h1234, 16'hFFFF, 16'h8000},
                '{16'd1, 16'h0000, 16'h0000, 16'h0000},
                '{16'd6, 16'h0300, 16'h00FF, 16'h0101}};
    bulk = '{50, 50, 45, 40, 30, 30, 45};

    rst       <= 1'b1;
    in_valid  <= 1'b0;
    mode      <= MODE_WEIGHT;
    from_node <= '0;
    to_node   <= '0;
    weight    <= '0;
    event_req <= EV_NONE;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_NODE_COUNT;
    cfg_data  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // no nodes in use after reset: every query is out of range, events drop
    send_word(MODE_QUERY, 5'd0, 5'd0, WEIGHT_MAX, EV_TYPE3);
    send_word(MODE_EVENT, 5'd0, 5'd1, '0, EV_TYPE1);
    send_word(MODE_SPARE, 5'd31, 5'd31, WEIGHT_MAX, EV_TYPE3);
    send_word(MODE_QUERY, 5'd31, 5'd31, '0, EV_NONE);
    settle();

    write_register(CFG_NODE_COUNT, 16'd4);
    write_register(CFG_EVENT1, 16'h0000);
    write_register(CFG_EVENT2, 16'hFFFF);
    write_register(CFG_EVENT3, 16'h0200);
    fill_matrix(4, 1'b1);
    send_word(MODE_WEIGHT, 5'd0, 5'd1, WEIGHT_MAX, EV_NONE);
    send_word(MODE_WEIGHT, 5'd1, 5'd2, WEIGHT_MAX, EV_NONE);
    send_word(MODE_QUERY, 5'd0, 5'd2, '0, EV_NONE);
    send_word(MODE_WEIGHT, 5'd0, 5'd2, 24'h000300, EV_NONE);
    send_word(MODE_QUERY, 5'd0, 5'd2, '0, EV_NONE);
    send_word(MODE_EVENT, 5'd0, 5'd2, '0, EV_TYPE1);
    send_word(MODE_EVENT, 5'd1, 5'd0, '0, EV_TYPE2);
    send_word(MODE_QUERY, 5'd0, 5'd2, '0, EV_NONE);
    send_word(MODE_EVENT, 5'd2, 5'd0, '0, EV_TYPE3);
    send_word(MODE_QUERY, 5'd0, 5'd2, '0, EV_NONE);
    send_word(MODE_EVENT, 5'd0, 5'd2, '0, EV_TYPE2);
    send_word(MODE_WEIGHT, 5'd0, 5'd2, WEIGHT_MAX, EV_NONE);
    send_word(MODE_QUERY, 5'd0, 5'd2, '0, EV_NONE);
    send_word(MODE_QUERY, 5'd1, 5'd0, '0, EV_NONE);
    send_word(MODE_EVENT, 5'd0, 5'd1, '0, EV_NONE);
    send_word(MODE_QUERY, 5'd0, 5'd2, '0, EV_NONE);
    send_word(MODE_EVENT, 5'd3, 5'd9, '0, EV_TYPE1);
    send_word(MODE_WEIGHT, 5'd31, 5'd31, WEIGHT_MAX, EV_TYPE3);
    send_word(MODE_QUERY, 5'd3, 5'd3, WEIGHT_MAX, EV_TYPE3);
    send_word(MODE_QUERY, 5'd4, 5'd0, '0, EV_NONE);
    send_word(MODE_QUERY, 5'd0, 5'd31, '0, EV_NONE);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_register(CFG_NODE_COUNT, setting[p][0]);
      write_register(CFG_EVENT1, setting[p][1]);
      write_register(CFG_EVENT2, setting[p][2]);
      write_register(CFG_EVENT3, setting[p][3]);
      nodes = int'(setting[p][0][CFG_NODE_BITS-1:0]);
      if (nodes > MAX_NODES) nodes = MAX_NODES;
      idle_pct = (p == 2) ? 0 : 37;
      // with every node in use, skip the matrix fill: same-node queries only
      if (nodes < MAX_NODES) fill_matrix(nodes, 1'b0);
      repeat (bulk[p]) random_word(nodes, nodes == MAX_NODES);
    end

    settle();
    if (ledger.mismatches == 0 && ledger.owed.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
